@@ rtl/timed_entry_table_core_macros.svh @@
// assertion macros used by the checker file
`ifndef TIMED_ENTRY_TABLE_CORE_MACROS_SVH
`define TIMED_ENTRY_TABLE_CORE_MACROS_SVH

// same-cycle implication, checked on the rising edge of aclk outside reset
`define TET_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on the rising edge of aclk outside reset
`define TET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tet_pkg.sv @@
// shared types and constants of the timed entry table
package tet_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CMD_W   = 3;
    localparam int KEY_W   = 16;
    localparam int KIND_W  = 4;
    localparam int COUNT_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 3'd0,
        CMD_CLEAR     = 3'd1,
        CMD_SUB       = 3'd2,
        CMD_QUERY     = 3'd3,
        CMD_CLEAR_ALL = 3'd4
    } cmd_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] count_left;
        logic [KIND_W-1:0]  kind_out;
        logic               timer_start;
        logic               table_full;
    } result_t;

endpackage

@@ rtl/timed_entry_table_core.sv @@
// top level of the timed entry table: request register, table and result register
// -----------------------------------------------------------------------------
// usage
//   s_* channel takes one request per accepted beat: command, effect id, kind,
//   amount and remove flag. m_* channel returns exactly one result per request
//   in request order: found, count_left, kind_out, timer_start, table_full.
//   an accepted request waits in the request register until the result
//   register is free or being taken, then moves there and shows on m_*
//   throughput: one request per cycle while m_ready is high; the whole
//   table lookup, update and result forming sit between the request
//   register and the result register
//   keys are matched against all slots in parallel; inserts take the lowest
//   free slot; the table update lands on the same edge as the result
//   reset (aresetn low, synchronous) empties the table and drops any
//   request or result in flight; slot contents themselves are not cleared
//   when m_ready is low the result register holds; the request register
//   still fills once, after which s_ready falls until the result is taken
// -----------------------------------------------------------------------------
module timed_entry_table_core
    import tet_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [KEY_W-1:0]   s_effect_id,
    input  logic [KIND_W-1:0]  s_kind_in,
    input  logic [COUNT_W-1:0] s_amount,
    input  logic               s_remove_flag,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic [COUNT_W-1:0] m_count_left,
    output logic [KIND_W-1:0]  m_kind_out,
    output logic               m_timer_start,
    output logic               m_table_full
);

    // request register
    logic               in_vld_reg, in_vld_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [KEY_W-1:0]   id_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [COUNT_W-1:0] amount_reg;
    logic               remove_reg;

    // result register
    logic    out_vld_reg, out_vld_next;
    result_t res_reg, res_next;

    // table storage; only the valid bits are reset
    logic [ENTRIES-1:0] slot_valid_reg, slot_valid_next;
    logic [KEY_W-1:0]   slot_key_reg   [ENTRIES];
    logic [KIND_W-1:0]  slot_kind_reg  [ENTRIES];
    logic [COUNT_W-1:0] slot_count_reg [ENTRIES];

    // lookup
    logic [ENTRIES-1:0] hit_vec;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               has_free;
    logic [IDX_W-1:0]   free_idx;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] sub_count;

    // write controls
    logic               ins_en;
    logic               cnt_en;
    logic [IDX_W-1:0]   cnt_idx;
    logic [COUNT_W-1:0] cnt_val;

    logic out_free;
    logic advance;

    // handshake: the result register frees when empty or being taken
    assign out_free = !out_vld_reg || m_ready;
    assign advance  = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    // parallel key compare; keys are distinct, so at most one hit
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            hit_vec[i] = slot_valid_reg[i] && (slot_key_reg[i] == id_reg);
            if (hit_vec[i]) begin
                hit_idx = IDX_W'(i);
            end
            // scanning downward leaves the lowest free slot
            if (!slot_valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit      = |hit_vec;
    assign has_free = !(&slot_valid_reg);

    // saturating subtract on the hit entry
    assign cur_count = slot_count_reg[hit_idx];
    assign sub_count = (amount_reg >= cur_count) ? '0 : COUNT_W'(cur_count - amount_reg);

    // command decode: table update and result
    always_comb begin
        slot_valid_next     = slot_valid_reg;
        ins_en              = 1'b0;
        cnt_en              = 1'b0;
        cnt_idx             = hit_idx;
        cnt_val             = amount_reg;
        res_next            = '0;
        res_next.found      = hit;
        unique case (cmd_reg)
            CMD_ADD: begin
                if (hit) begin
                    // refresh of an existing entry
                    cnt_en = 1'b1;
                end else if (has_free) begin
                    ins_en                    = 1'b1;
                    cnt_en                    = 1'b1;
                    cnt_idx                   = free_idx;
                    slot_valid_next[free_idx] = 1'b1;
                    res_next.timer_start      = 1'b1;
                end else begin
                    // new key, no room: dropped
                    res_next.table_full = 1'b1;
                end
            end
            CMD_CLEAR: begin
                if (hit) begin
                    if (remove_reg) begin
                        slot_valid_next[hit_idx] = 1'b0;
                    end else begin
                        cnt_en  = 1'b1;
                        cnt_val = '0;
                    end
                end
            end
            CMD_SUB: begin
                if (hit) begin
                    cnt_en              = 1'b1;
                    cnt_val             = sub_count;
                    res_next.count_left = sub_count;
                    // reaching zero, exactly or by clamping
                    if (remove_reg && (sub_count == '0)) begin
                        slot_valid_next[hit_idx] = 1'b0;
                    end
                end
            end
            CMD_QUERY: begin
                if (hit) begin
                    res_next.kind_out = slot_kind_reg[hit_idx];
                end
            end
            CMD_CLEAR_ALL: begin
                slot_valid_next = '0;
            end
            default: begin
                // undefined command codes leave the table alone
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            slot_valid_reg <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                slot_valid_reg <= slot_valid_next;
            end
        end
    end

    // request payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg    <= s_cmd;
            id_reg     <= s_effect_id;
            kind_reg   <= s_kind_in;
            amount_reg <= s_amount;
            remove_reg <= s_remove_flag;
        end
    end

    // table payload and result capture, on the same edge
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
            if (ins_en) begin
                slot_key_reg[free_idx]  <= id_reg;
                slot_kind_reg[free_idx] <= kind_reg;
            end
            if (cnt_en) begin
                slot_count_reg[cnt_idx] <= cnt_val;
            end
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_found       = res_reg.found;
    assign m_count_left  = res_reg.count_left;
    assign m_kind_out    = res_reg.kind_out;
    assign m_timer_start = res_reg.timer_start;
    assign m_table_full  = res_reg.table_full;

endmodule

@@ rtl/tet_checker.sv @@
// port-level checker for the timed entry table, bound to the top level
`include "timed_entry_table_core_macros.svh"

module tet_checker
    import tet_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [CMD_W-1:0]   s_cmd,
    input logic [KEY_W-1:0]   s_effect_id,
    input logic [KIND_W-1:0]  s_kind_in,
    input logic [COUNT_W-1:0] s_amount,
    input logic               s_remove_flag,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_found,
    input logic [COUNT_W-1:0] m_count_left,
    input logic [KIND_W-1:0]  m_kind_out,
    input logic               m_timer_start,
    input logic               m_table_full
);

    // a waiting request holds its payload
    `TET_ASSERT_NEXT(a_request_hold, s_valid && !s_ready, s_valid && $stable(s_cmd) && $stable(s_effect_id) && $stable(s_kind_in) && $stable(s_amount) && $stable(s_remove_flag), "request changed while waiting")

    // a stalled result holds
    `TET_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_count_left) && $stable(m_kind_out) && $stable(m_found), "result changed while stalled")

    // an insert and a drop cannot both come from one add
    `TET_ASSERT_NOW(a_start_or_full, m_valid, !(m_timer_start && m_table_full), "timer_start and table_full together")

    // inserts and drops only happen for keys that were absent
    `TET_ASSERT_NOW(a_new_key_only, m_valid && (m_timer_start || m_table_full), !m_found, "insert or drop reported for a present key")

    // a nonzero count or kind needs a hit
    `TET_ASSERT_NOW(a_data_needs_hit, m_valid && ((m_count_left != '0) || (m_kind_out != '0)), m_found, "data returned without a hit")

endmodule

bind timed_entry_table_core tet_checker u_tet_checker (.*);

@@ sim/timed_entry_table_core_test.sv @@
// self-checking testbench for the timed entry table core
module timed_entry_table_core_test;
    import tet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one request as it appears on the s_* ports
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   effect_id;
        logic [KIND_W-1:0]  kind_in;
        logic [COUNT_W-1:0] amount;
        logic               remove_flag;
    } req_t;

    // first command code with no meaning; everything from here up is ignored
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = CMD_CLEAR_ALL + 1'b1;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = '1;

    localparam int RANDOM_REQS  = 1750;
    localparam int POOL_SIZE    = 20;    // a few more keys than slots, so the table fills
    localparam int QUIET_LIMIT  = 1000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 8;     // extra watch after the last result comes back

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [CMD_W-1:0]   s_cmd = '0;
    logic [KEY_W-1:0]   s_effect_id = '0;
    logic [KIND_W-1:0]  s_kind_in = '0;
    logic [COUNT_W-1:0] s_amount = '0;
    logic               s_remove_flag = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_found;
    logic [COUNT_W-1:0] m_count_left;
    logic [KIND_W-1:0]  m_kind_out;
    logic               m_timer_start;
    logic               m_table_full;

    timed_entry_table_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_effect_id   (s_effect_id),
        .s_kind_in     (s_kind_in),
        .s_amount      (s_amount),
        .s_remove_flag (s_remove_flag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_count_left  (m_count_left),
        .m_kind_out    (m_kind_out),
        .m_timer_start (m_timer_start),
        .m_table_full  (m_table_full)
    );

    // requests waiting to be driven, results the table should produce
    req_t    pending_reqs[$];
    result_t expected_results[$];

    // shadow copy of the table contents
    logic [ENTRIES-1:0] ent_live = '0;
    logic [KEY_W-1:0]   ent_key[ENTRIES];
    logic [KIND_W-1:0]  ent_kind[ENTRIES];
    logic [COUNT_W-1:0] ent_count[ENTRIES];

    int unsigned n_req_accepted = 0;
    int unsigned n_res_accepted = 0;
    int unsigned n_errors = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // runs the shadow table through one request and returns the result it gives
    function automatic result_t apply_request(req_t r);
        int hit;
        int free_idx;
        result_t res;
        logic [COUNT_W-1:0] left;
        res = '0;
        hit = -1;
        free_idx = -1;
        // keys are unique among live slots, so the first match is the only one
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && ent_live[i] && ent_key[i] == r.effect_id) hit = i;
            if (free_idx < 0 && !ent_live[i]) free_idx = i;
        end
        case (r.cmd)
            CMD_ADD: begin
                if (hit >= 0) begin
                    // refresh only, kind stays as first inserted
                    ent_count[hit] = r.amount;
                end else if (free_idx >= 0) begin
                    ent_live[free_idx]  = 1'b1;
                    ent_key[free_idx]   = r.effect_id;
                    ent_kind[free_idx]  = r.kind_in;
                    ent_count[free_idx] = r.amount;
                    res.timer_start = 1'b1;
                end else begin
                    res.table_full = 1'b1;
                end
            end
            CMD_CLEAR: begin
                if (hit >= 0) begin
                    if (r.remove_flag) ent_live[hit] = 1'b0;
                    else ent_count[hit] = '0;
                end
            end
            CMD_SUB: begin
                if (hit >= 0) begin
                    // saturate at zero; landing exactly on zero also allows the erase
                    left = (r.amount >= ent_count[hit]) ? '0 : ent_count[hit] - r.amount;
                    ent_count[hit] = left;
                    res.count_left = left;
                    if (left == '0 && r.remove_flag) ent_live[hit] = 1'b0;
                end
            end
            CMD_QUERY: begin
                if (hit >= 0) res.kind_out = ent_kind[hit];
            end
            CMD_CLEAR_ALL: begin
                ent_live = '0;
            end
            default: begin
            end
        endcase
        // found reflects the lookup before the update, for every command
        res.found = (hit >= 0);
        return res;
    endfunction

    // idle cycles before the next handshake; every fourth stretch runs flat out
    function automatic int unsigned idle_cycles();
        if ((n_req_accepted / 128) % 4 == 3) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] id,
                             input logic [KIND_W-1:0] kind, input logic [COUNT_W-1:0] amt,
                             input logic rm);
        req_t r;
        r.cmd = cmd;
        r.effect_id = id;
        r.kind_in = kind;
        r.amount = amt;
        r.remove_flag = rm;
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("result %0d: %s expected %0h got %0h", n_res_accepted, what, want, got);
        n_errors++;
    endtask

    // request driver: holds a request until taken, then waits its drawn gap
    always @(posedge aclk) begin : drive_requests
        req_t nxt;
        req_t taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                taken.cmd = s_cmd;
                taken.effect_id = s_effect_id;
                taken.kind_in = s_kind_in;
                taken.amount = s_amount;
                taken.remove_flag = s_remove_flag;
                expected_results = {expected_results, apply_request(taken)};
                n_req_accepted++;
            end
            // a request still waiting for s_ready keeps its payload untouched
            if (!(s_valid && !s_ready)) begin
                if (gap_left != 0) begin
                    s_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_reqs.size() != 0) begin
                    nxt = pending_reqs.pop_front();
                    s_cmd <= nxt.cmd;
                    s_effect_id <= nxt.effect_id;
                    s_kind_in <= nxt.kind_in;
                    s_amount <= nxt.amount;
                    s_remove_flag <= nxt.remove_flag;
                    s_valid <= 1'b1;
                    gap_left <= idle_cycles();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each taken result, then stalls m_ready for a drawn time
    always @(posedge aclk) begin : collect_results
        result_t want;
        int unsigned draw;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", 0, 1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_found !== want.found)
                        report_mismatch("found", want.found, m_found);
                    if (m_count_left !== want.count_left)
                        report_mismatch("count_left", want.count_left, m_count_left);
                    if (m_kind_out !== want.kind_out)
                        report_mismatch("kind_out", want.kind_out, m_kind_out);
                    if (m_timer_start !== want.timer_start)
                        report_mismatch("timer_start", want.timer_start, m_timer_start);
                    if (m_table_full !== want.table_full)
                        report_mismatch("table_full", want.table_full, m_table_full);
                end
                n_res_accepted++;
                draw = idle_cycles();
                stall_left <= draw;
                m_ready <= (draw == 0);
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready <= (stall_left == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: a hang shows as a long run of cycles with no handshake at all
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0]   key_pool[POOL_SIZE];
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] amt;
        logic [CMD_W-1:0]   cmd;
        int unsigned        pick;
        int unsigned        amt_sel;

        // directed: edge keys, refresh, clamp, erase at zero, misses, unused codes
        queue_req(CMD_ADD, 16'h0000, 4'h0, 16'h0000, 1'b0);     // insert, lowest key
        queue_req(CMD_ADD, 16'hFFFF, 4'hF, 16'hFFFF, 1'b1);     // insert, all ones
        queue_req(CMD_ADD, 16'h0000, 4'hA, 16'h0005, 1'b0);     // refresh keeps kind 0
        queue_req(CMD_QUERY, 16'hFFFF, 4'h0, 16'h0000, 1'b0);
        queue_req(CMD_QUERY, 16'h0000, 4'h0, 16'h0000, 1'b0);
        queue_req(CMD_SUB, 16'hFFFF, 4'h0, 16'h0001, 1'b1);     // nonzero left, no erase
        queue_req(CMD_SUB, 16'hFFFF, 4'h0, 16'hFFFF, 1'b0);     // clamps to zero, kept
        queue_req(CMD_SUB, 16'hFFFF, 4'h0, 16'h0000, 1'b1);     // zero minus zero erases
        queue_req(CMD_QUERY, 16'hFFFF, 4'h0, 16'h0000, 1'b0);   // now a miss
        queue_req(CMD_CLEAR, 16'h0000, 4'h0, 16'h0000, 1'b0);   // zero the count
        queue_req(CMD_SUB, 16'h0000, 4'h0, 16'h0003, 1'b0);
        queue_req(CMD_CLEAR, 16'h0000, 4'h0, 16'h0000, 1'b1);   // erase
        queue_req(CMD_CLEAR, 16'h0000, 4'h0, 16'h0000, 1'b1);   // miss
        queue_req(CMD_SUB, 16'h1234, 4'h0, 16'h0001, 1'b1);     // miss
        queue_req(CMD_RSVD_FIRST, 16'h0000, 4'hF, 16'hFFFF, 1'b1);
        queue_req(CMD_RSVD_LAST, 16'h0001, 4'hF, 16'hFFFF, 1'b1);
        // fill every slot, then a dropped add and a refresh that still lands
        for (int i = 1; i <= ENTRIES; i++)
            queue_req(CMD_ADD, KEY_W'(i), KIND_W'(i), COUNT_W'(i), 1'b0);
        queue_req(CMD_ADD, KEY_W'(ENTRIES + 1), 4'h3, 16'h0007, 1'b0);
        queue_req(CMD_ADD, 16'h0001, 4'h3, 16'h0009, 1'b0);
        queue_req(CMD_CLEAR_ALL, 16'h0001, 4'h0, 16'h0000, 1'b0);
        queue_req(CMD_QUERY, 16'h0001, 4'h0, 16'h0000, 1'b0);

        // random: mostly keys from a small pool so hits, erasures and a full table recur
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else key = KEY_W'($urandom);
            amt_sel = $urandom_range(0, 9);
            if (amt_sel < 5) amt = COUNT_W'($urandom_range(0, 20));
            else if (amt_sel < 9) amt = COUNT_W'($urandom);
            else if (amt_sel[0]) amt = '1;
            else amt = '0;
            pick = $urandom_range(0, 99);
            if (pick < 36) cmd = CMD_ADD;
            else if (pick < 58) cmd = CMD_SUB;
            else if (pick < 74) cmd = CMD_QUERY;
            else if (pick < 92) cmd = CMD_CLEAR;
            else if (pick < 93) cmd = CMD_CLEAR_ALL;
            else cmd = CMD_W'($urandom);   // any code, unused ones included
            queue_req(cmd, key, KIND_W'($urandom), amt, 1'($urandom));
        end

        // synchronous reset, held and then released
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // let every request go out and every result come back, then watch a little longer
        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
